// ===== sv/depq_pkg.sv =====
package depq_pkg;

   localparam int DEF_CAPACITY      = 16;
   localparam int DEF_DATA_BITS     = 32;
   localparam int DEF_PRIORITY_BITS = 16;

   localparam logic [1:0] CMD_INSERT       = 2'd0;
   localparam logic [1:0] CMD_REMOVE_FRONT = 2'd1;
   localparam logic [1:0] CMD_REMOVE_BACK  = 2'd2;
   localparam logic [1:0] CMD_PEEK         = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic       is_full;
      logic       is_empty;
      logic [1:0] status;
   } depq_flags_type;

endpackage

// ===== sv/depq_mem.sv =====
module depq_mem
   import depq_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int WIDTH = DEF_DATA_BITS + DEF_PRIORITY_BITS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_entry,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_entry_a,
   output logic [WIDTH-1:0] rd_entry_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_entry_a_ff;
   logic [WIDTH-1:0] rd_entry_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_a_ff <= mem[rd_addr_a];
         rd_entry_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_entry_a = rd_entry_a_ff;
   assign rd_entry_b = rd_entry_b_ff;

endmodule

// ===== sv/depq_ctrl.sv =====
module depq_ctrl
   import depq_pkg::*;
#(
   parameter int CAPACITY      = DEF_CAPACITY,
   parameter int DATA_BITS     = DEF_DATA_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int EW = DATA_BITS + PRIORITY_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [1:0]                      cmd,
   input  logic signed [DATA_BITS-1:0]     item_data,
   input  logic signed [PRIORITY_BITS-1:0] item_priority,
   output logic                            ready,
   output logic                            done,
   input  logic                            ack,
   output logic signed [DATA_BITS-1:0]     front_data,
   output logic signed [PRIORITY_BITS-1:0] front_priority,
   output logic signed [DATA_BITS-1:0]     back_data,
   output logic signed [PRIORITY_BITS-1:0] back_priority,
   output logic [CW-1:0]                   entry_count,
   output depq_flags_type                  flags,
   output logic                            mem_wr_en,
   output logic [AW-1:0]                   mem_wr_addr,
   output logic [EW-1:0]                   mem_wr_entry,
   output logic                            mem_rd_en,
   output logic [AW-1:0]                   mem_rd_addr_a,
   output logic [AW-1:0]                   mem_rd_addr_b,
   input  logic [EW-1:0]                   mem_rd_entry_a,
   input  logic [EW-1:0]                   mem_rd_entry_b
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_RD  = 3'd1;
   localparam logic [2:0] ST_INS_CMP = 3'd2;
   localparam logic [2:0] ST_INS_PUT = 3'd3;
   localparam logic [2:0] ST_POP_RD  = 3'd4;
   localparam logic [2:0] ST_POP_WR  = 3'd5;
   localparam logic [2:0] ST_FIN_RD  = 3'd6;
   localparam logic [2:0] ST_FIN_CAP = 3'd7;

   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [2:0]    state_ff,  state_in;
   logic [AW-1:0] idx_ff,    idx_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [EW-1:0] item_ff,   item_in;
   logic [1:0]    status_ff, status_in;

   logic [EW-1:0] new_entry;
   logic          moves_up;

   assign new_entry = {item_priority, item_data};
   assign moves_up  = $signed(mem_rd_entry_a[EW-1:DATA_BITS]) > $signed(item_ff[EW-1:DATA_BITS]);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      item_in       = item_ff;
      status_in     = status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff + AW'(1);
      mem_wr_entry  = item_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr_a = idx_ff;
      mem_rd_addr_b = (count_ff == '0) ? '0 : AW'(count_ff - CW'(1));
      done          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in   = new_entry;
               status_in = STATUS_OK;
               state_in  = ST_FIN_RD;
               case (cmd)
                  CMD_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STATUS_OVERFLOW;
                     end else if (count_ff == '0) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = '0;
                        mem_wr_entry = new_entry;
                        count_in     = CW'(1);
                     end else begin
                        idx_in   = AW'(count_ff - CW'(1));
                        state_in = ST_INS_RD;
                     end
                  end
                  CMD_REMOVE_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else if (count_ff == CW'(1)) begin
                        count_in = '0;
                     end else begin
                        idx_in   = AW'(1);
                        state_in = ST_POP_RD;
                     end
                  end
                  CMD_REMOVE_BACK: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (moves_up) begin
               mem_wr_entry = mem_rd_entry_a;
               if (idx_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = ST_INS_RD;
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_FIN_RD;
            end
         end
         ST_INS_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            count_in    = count_ff + CW'(1);
            state_in    = ST_FIN_RD;
         end
         ST_POP_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_POP_WR;
         end
         ST_POP_WR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = idx_ff - AW'(1);
            mem_wr_entry = mem_rd_entry_a;
            if (CW'(idx_ff) == count_ff - CW'(1)) begin
               count_in = count_ff - CW'(1);
               state_in = ST_FIN_RD;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_POP_RD;
            end
         end
         ST_FIN_RD: begin
            mem_rd_en     = 1'b1;
            mem_rd_addr_a = '0;
            state_in      = ST_FIN_CAP;
         end
         ST_FIN_CAP: begin
            done = 1'b1;
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      item_ff   <= item_in;
      status_ff <= status_in;
   end

   assign ready          = (state_ff == ST_IDLE);
   assign entry_count    = count_ff;
   assign front_data     = (count_ff == '0) ? '0 : mem_rd_entry_a[DATA_BITS-1:0];
   assign front_priority = (count_ff == '0) ? '0 : mem_rd_entry_a[EW-1:DATA_BITS];
   assign back_data      = (count_ff == '0) ? '0 : mem_rd_entry_b[DATA_BITS-1:0];
   assign back_priority  = (count_ff == '0) ? '0 : mem_rd_entry_b[EW-1:DATA_BITS];

   always_comb begin
      flags.is_full  = (count_ff == FULL_COUNT);
      flags.is_empty = (count_ff == '0);
      flags.status   = status_ff;
   end

endmodule

// ===== sv/double_ended_priority_queue.sv =====
// Double-ended priority queue held as a sorted table in a small memory.
// Requests arrive on the req_ channel: req_tuser carries the command (insert,
// remove front, remove back, peek), req_tdata the data and priority to insert.
// Each request produces exactly one response on the rsp_ channel giving the
// front and back entries, the entry count, the empty and full flags, and in
// rsp_tuser a status (ok, underflow, overflow).
// One request is worked on at a time. An insert walks the table from the back,
// reading and moving one entry at a time; a remove of the front moves every
// remaining entry down in the same way, and an insert only walks a table that
// is not full. The single read-modify-write path through the table memory
// sets the pace of this walk.
// The response sits in an output register, so the next request is taken while
// an earlier response waits. If the receiver stalls, the following response
// is held inside the block and no further request is taken until it leaves.
// Reset empties the queue; the table contents themselves are not cleared.
module double_ended_priority_queue
   import depq_pkg::*;
#(
   parameter int CAPACITY      = DEF_CAPACITY,
   parameter int DATA_BITS     = DEF_DATA_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int CW       = $clog2(CAPACITY + 1),
   localparam int EW       = DATA_BITS + PRIORITY_BITS,
   localparam int IN_W     = ((EW + 7) / 8) * 8,
   localparam int OUT_RAW  = 2 * EW + CW + 2,
   localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // item_data, item_priority
   input  logic [IN_W-1:0]  req_tdata,
   // cmd
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // front_data, front_priority, back_data, back_priority, entry_count, is_empty, is_full
   output logic [OUT_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                            start;
   logic                            ready;
   logic                            done;
   logic                            ack;
   logic signed [DATA_BITS-1:0]     front_data;
   logic signed [PRIORITY_BITS-1:0] front_priority;
   logic signed [DATA_BITS-1:0]     back_data;
   logic signed [PRIORITY_BITS-1:0] back_priority;
   logic [CW-1:0]                   entry_count;
   depq_flags_type                  flags;

   logic                            mem_wr_en;
   logic [AW-1:0]                   mem_wr_addr;
   logic [EW-1:0]                   mem_wr_entry;
   logic                            mem_rd_en;
   logic [AW-1:0]                   mem_rd_addr_a;
   logic [AW-1:0]                   mem_rd_addr_b;
   logic [EW-1:0]                   mem_rd_entry_a;
   logic [EW-1:0]                   mem_rd_entry_b;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]                rsp_tdata_ff,  rsp_tdata_in;
   logic [1:0]                      rsp_tuser_ff,  rsp_tuser_in;

   assign req_tready = ready;
   assign start      = req_tvalid & ready;
   assign ack        = done & (~rsp_tvalid_ff | rsp_tready);

   depq_ctrl #(
      .CAPACITY      (CAPACITY),
      .DATA_BITS     (DATA_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .cmd            (req_tuser),
      .item_data      (req_tdata[DATA_BITS-1:0]),
      .item_priority  (req_tdata[EW-1:DATA_BITS]),
      .ready          (ready),
      .done           (done),
      .ack            (ack),
      .front_data     (front_data),
      .front_priority (front_priority),
      .back_data      (back_data),
      .back_priority  (back_priority),
      .entry_count    (entry_count),
      .flags          (flags),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_entry   (mem_wr_entry),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr_a  (mem_rd_addr_a),
      .mem_rd_addr_b  (mem_rd_addr_b),
      .mem_rd_entry_a (mem_rd_entry_a),
      .mem_rd_entry_b (mem_rd_entry_b)
   );

   depq_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_entry   (mem_wr_entry),
      .rd_en      (mem_rd_en),
      .rd_addr_a  (mem_rd_addr_a),
      .rd_addr_b  (mem_rd_addr_b),
      .rd_entry_a (mem_rd_entry_a),
      .rd_entry_b (mem_rd_entry_b)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (ack) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = OUT_W'({flags.is_full, flags.is_empty, entry_count,
                                 back_priority, back_data, front_priority, front_data});
         rsp_tuser_in  = flags.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== sv/depq_checker.sv =====
module depq_checker
   import depq_pkg::*;
#(
   parameter int CAPACITY      = DEF_CAPACITY,
   parameter int DATA_BITS     = DEF_DATA_BITS,
   parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
   localparam int CW      = $clog2(CAPACITY + 1),
   localparam int EW      = DATA_BITS + PRIORITY_BITS,
   localparam int OUT_RAW = 2 * EW + CW + 2,
   localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic [1:0]       rsp_tuser
);

   localparam int CNT_LO   = 2 * EW;
   localparam int EMPTY_AT = 2 * EW + CW;
   localparam int FULL_AT  = 2 * EW + CW + 1;

   logic [CW-1:0] rsp_count;
   assign rsp_count = rsp_tdata[EMPTY_AT-1:CNT_LO];

   // A stalled response must keep its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A request is never taken in the cycle right after another one was taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is still in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[EMPTY_AT] == (rsp_count == '0))
      else $error("empty flag disagrees with the count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FULL_AT] == (rsp_count == CW'(CAPACITY)))
      else $error("full flag disagrees with the count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OVERFLOW |-> rsp_tdata[FULL_AT])
      else $error("overflow reported while the queue is not full");

endmodule

bind double_ended_priority_queue depq_checker #(
   .CAPACITY      (CAPACITY),
   .DATA_BITS     (DATA_BITS),
   .PRIORITY_BITS (PRIORITY_BITS)
) u_depq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb.sv =====
module tb;
   import depq_pkg::*;

   localparam int CAPACITY      = DEF_CAPACITY;
   localparam int IN_W          = 48;
   localparam int OUT_W         = 104;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int PHASE_ITEMS   = 160;

   typedef struct {
      logic [31:0] front_data;
      logic [15:0] front_priority;
      logic [31:0] back_data;
      logic [15:0] back_priority;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic        is_full;
      logic [1:0]  status;
   } queue_view_type;

   class sorted_queue_tracker;
      logic [31:0]        entry_data [CAPACITY];
      logic signed [15:0] entry_priority [CAPACITY];
      int                 held;
      queue_view_type     expected_views [$];
      int                 failures;
      int                 mismatch_count;

      function new();
         held = 0;
         failures = 0;
         mismatch_count = 0;
      endfunction

      function void note_request(logic [1:0] cmd, logic [31:0] data,
                                 logic signed [15:0] prio);
         queue_view_type view;
         int             pos;
         int             i;
         view.status = STATUS_OK;
         case (cmd)
            CMD_INSERT: begin
               if (held >= CAPACITY) begin
                  view.status = STATUS_OVERFLOW;
               end else begin
                  pos = 0;
                  while (pos < held && entry_priority[pos] <= prio) pos++;
                  for (i = held; i > pos; i--) begin
                     entry_data[i] = entry_data[i-1];
                     entry_priority[i] = entry_priority[i-1];
                  end
                  entry_data[pos] = data;
                  entry_priority[pos] = prio;
                  held++;
               end
            end
            CMD_REMOVE_FRONT: begin
               if (held == 0) begin
                  view.status = STATUS_UNDERFLOW;
               end else begin
                  for (i = 0; i + 1 < held; i++) begin
                     entry_data[i] = entry_data[i+1];
                     entry_priority[i] = entry_priority[i+1];
                  end
                  held--;
               end
            end
            CMD_REMOVE_BACK: begin
               if (held == 0) view.status = STATUS_UNDERFLOW;
               else held--;
            end
            default: begin
            end
         endcase
         if (held == 0) begin
            view.front_data = '0;
            view.front_priority = '0;
            view.back_data = '0;
            view.back_priority = '0;
         end else begin
            view.front_data = entry_data[0];
            view.front_priority = entry_priority[0];
            view.back_data = entry_data[held-1];
            view.back_priority = entry_priority[held-1];
         end
         view.entry_count = held[4:0];
         view.is_empty = (held == 0);
         view.is_full = (held >= CAPACITY);
         expected_views.push_back(view);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch in %s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_response(logic [OUT_W-1:0] tdata, logic [1:0] tuser);
         queue_view_type want;
         if (expected_views.size() == 0) begin
            failures++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response %h/%h arrived with no request pending", tdata, tuser);
            return;
         end
         want = expected_views.pop_front();
         compare_field("front_data", want.front_data, tdata[31:0]);
         compare_field("front_priority", 32'(want.front_priority), 32'(tdata[47:32]));
         compare_field("back_data", want.back_data, tdata[79:48]);
         compare_field("back_priority", 32'(want.back_priority), 32'(tdata[95:80]));
         compare_field("entry_count", 32'(want.entry_count), 32'(tdata[100:96]));
         compare_field("is_empty", 32'(want.is_empty), 32'(tdata[101]));
         compare_field("is_full", 32'(want.is_full), 32'(tdata[102]));
         compare_field("status", 32'(want.status), 32'(tuser));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;
   logic [1:0]       req_tuser = CMD_PEEK;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               cycle_count = 0;
   bit               filling = 1'b0;
   sorted_queue_tracker tracker = new();

   double_ended_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[double_ended_priority_queue] ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [31:0] data,
                               input logic [15:0] prio);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {prio, data};
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.note_request(cmd, data, prio);
   endtask

   // The mix leans towards inserts while filling and towards removals while
   // draining, so the queue swings between empty and full and meets both limits.
   task automatic send_random_request();
      logic [1:0]  cmd;
      logic [31:0] data;
      logic [15:0] prio;
      int          pick;
      if (tracker.held == CAPACITY && $urandom_range(1)) filling = 1'b0;
      if (tracker.held == 0 && $urandom_range(1)) filling = 1'b1;
      pick = $urandom_range(99);
      if (filling) begin
         cmd = pick < 60 ? CMD_INSERT : pick < 75 ? CMD_REMOVE_FRONT :
               pick < 88 ? CMD_REMOVE_BACK : CMD_PEEK;
      end else begin
         cmd = pick < 15 ? CMD_INSERT : pick < 50 ? CMD_REMOVE_FRONT :
               pick < 85 ? CMD_REMOVE_BACK : CMD_PEEK;
      end
      data = $urandom();
      pick = $urandom_range(99);
      if (pick < 45) prio = 16'($urandom_range(6) - 3);
      else if (pick < 55) prio = $urandom_range(1) ? 16'h7fff : 16'h8000;
      else prio = 16'($urandom());
      send_request(cmd, data, prio);
   endtask

   task automatic wait_for_drain();
      while (tracker.expected_views.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(CMD_PEEK, 32'h0, 16'h0);
      send_request(CMD_REMOVE_FRONT, 32'h0, 16'h0);
      send_request(CMD_REMOVE_BACK, 32'h0, 16'h0);
      send_request(CMD_INSERT, 32'h7fffffff, 16'h0000);
      send_request(CMD_INSERT, 32'h80000000, 16'h7fff);
      send_request(CMD_INSERT, 32'h00000000, 16'h8000);
      send_request(CMD_INSERT, 32'hffffffff, 16'hffff);
      send_request(CMD_INSERT, 32'h00000001, 16'h0000);
      send_request(CMD_INSERT, 32'h00000005, 16'h7fff);
      send_request(CMD_INSERT, 32'h00000006, 16'h8000);
      for (n = 0; n < CAPACITY - 7; n++)
         send_request(CMD_INSERT, $urandom(), 16'($urandom_range(4) - 2));
      send_request(CMD_INSERT, 32'hffffffff, 16'h0000);
      send_request(CMD_PEEK, 32'h0, 16'h0);
      send_request(CMD_REMOVE_FRONT, 32'h0, 16'h0);
      send_request(CMD_REMOVE_BACK, 32'h0, 16'h0);
      req_tvalid <= 1'b0;
      wait_for_drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct <= 70;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 70;
            end
            default: begin
               sender_idle_pct <= 27;
               receiver_stall_pct <= 27;
            end
         endcase
         @(posedge clock);
         repeat (PHASE_ITEMS) send_random_request();
         req_tvalid <= 1'b0;
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.expected_views.size() == 0) begin
         $display("[double_ended_priority_queue] OK");
      end else begin
         $display("[double_ended_priority_queue] ERROR");
      end
      $finish;
   end
endmodule
